// ===== rtl/csd_pkg.sv =====
// Shared types and constants of the cycle-slip detector.
`timescale 1ns / 1ps
package csd_pkg;

    localparam int FRAC_BITS  = 12;
    localparam int DATA_W     = 48;
    localparam int FREQ_W     = 12;
    localparam int LIMIT_W    = 20;
    localparam int CNT_W      = 16;
    localparam int KEY_W      = 8;
    localparam int PRN_W      = 6;
    localparam int COEF_W     = 24;
    localparam int PROD_W     = 48;
    localparam int ACC_W      = 80;
    localparam int Q_W        = 62;
    localparam int REM_W      = 25;
    localparam int STEP_W     = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 168;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_GPS_F1   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GPS_F2   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BDS_F1   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BDS_F2   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MW_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GF_LIMIT = 3'd5;

    localparam logic [FREQ_W-1:0] GPS_F1_RST = 12'd1540;
    localparam logic [FREQ_W-1:0] GPS_F2_RST = 12'd1200;
    localparam logic [FREQ_W-1:0] BDS_F1_RST = 12'd1526;
    localparam logic [FREQ_W-1:0] BDS_F2_RST = 12'd1240;

    localparam longint MW_RAW   = 64'd3 << FRAC_BITS;
    localparam longint GF_RAW   = ((64'd5 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint LIM_MAX  = 64'hF_FFFF;
    localparam logic [LIMIT_W-1:0] MW_LIMIT_RST = LIMIT_W'(MW_RAW > LIM_MAX ? LIM_MAX : MW_RAW);
    localparam logic [LIMIT_W-1:0] GF_LIMIT_RST = LIMIT_W'(GF_RAW > LIM_MAX ? LIM_MAX : GF_RAW);

    // Quotient magnitude clamp, 2^60.
    localparam logic [ACC_W:0] Q_CLAMP = (ACC_W + 1)'(1) << 60;

    // Which division the shared unit is working on.
    localparam logic [1:0] SEL_WL   = 2'd0;
    localparam logic [1:0] SEL_NL   = 2'd1;
    localparam logic [1:0] SEL_IF   = 2'd2;
    localparam logic [1:0] SEL_MEAN = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] mw;
        logic [DATA_W-1:0] gf;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       mul;
        logic       acc;
        logic       div_init;
        logic       div_step;
        logic       div_fin;
        logic       calc;
        logic       srch_clr;
        logic       srch_rd;
        logic       srch_chk;
        logic       finish;
        logic [1:0] sel;
        logic [1:0] step;
    } cmd_t;

    typedef struct packed {
        logic missing;
        logic srch_end;
        logic hit;
        logic ok;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/csd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module csd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csd_ctrl.sv =====
// Sequencer of the cycle-slip detector: steps the shared multiply/divide datapath.
`timescale 1ns / 1ps
module csd_ctrl import csd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PREP    = 4'd1;
    localparam logic [3:0] ST_MUL     = 4'd2;
    localparam logic [3:0] ST_ACC     = 4'd3;
    localparam logic [3:0] ST_DIVINIT = 4'd4;
    localparam logic [3:0] ST_DIV     = 4'd5;
    localparam logic [3:0] ST_DIVFIN  = 4'd6;
    localparam logic [3:0] ST_CALC    = 4'd7;
    localparam logic [3:0] ST_SRD     = 4'd8;
    localparam logic [3:0] ST_SCHK    = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(3);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(ACC_W - 1);

    logic [3:0]        state_reg, state_next;
    logic [1:0]        sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_WL;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.step   = step_reg[1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = SEL_WL;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (sts.missing)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    state_next = ST_DIVINIT;
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_DIVFIN;
                end
            end
            ST_DIVFIN:
            begin
                cmd.div_fin = 1'b1;
                case (sel_reg)
                    SEL_WL:
                    begin
                        sel_next   = SEL_NL;
                        state_next = ST_PREP;
                    end
                    SEL_NL:
                    begin
                        sel_next   = SEL_IF;
                        state_next = ST_PREP;
                    end
                    SEL_IF:
                    begin
                        state_next = ST_CALC;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CALC:
            begin
                cmd.calc     = 1'b1;
                cmd.srch_clr = 1'b1;
                state_next   = ST_SRD;
            end
            ST_SRD:
            begin
                if (sts.srch_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = ST_SCHK;
                end
            end
            ST_SCHK:
            begin
                cmd.srch_chk = 1'b1;
                if (sts.hit && sts.ok)
                begin
                    sel_next   = SEL_MEAN;
                    state_next = ST_DIVINIT;
                end
                else if (sts.hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SRD;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/csd_datapath.sv =====
// Datapath: configuration, combination arithmetic, serial divider, table access, output beat.
`timescale 1ns / 1ps
module csd_datapath import csd_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    localparam int ADDR_W = $clog2(2 * TABLE_DEPTH),
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [LIMIT_W-1:0]    cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  ram_we,
    output logic [ADDR_W-1:0]     ram_waddr,
    output logic [ENTRY_W-1:0]    ram_wdata,
    output logic                  ram_re,
    output logic [ADDR_W-1:0]     ram_raddr,
    input  logic [ENTRY_W-1:0]    ram_rdata
);

    localparam logic [FILL_W-1:0] FULL = FILL_W'(TABLE_DEPTH);

    function automatic logic [DATA_W-1:0] sat48(input logic [63:0] v);
        logic signed [63:0] sv;
        sv = $signed(v);
        if (sv > $signed(64'h0000_7FFF_FFFF_FFFF))
            return 48'h7FFF_FFFF_FFFF;
        else if (sv < $signed(64'hFFFF_8000_0000_0000))
            return 48'h8000_0000_0000;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic bank,
                                                    input logic [FILL_W-1:0] idx);
        if (bank)
            return ADDR_W'(TABLE_DEPTH) + ADDR_W'(idx);
        else
            return ADDR_W'(idx);
    endfunction

    function automatic logic dgf_calc_sign(input logic [DATA_W-1:0] a,
                                           input logic [DATA_W-1:0] b);
        logic [48:0] d;
        d = {a[47], a} - {b[47], b};
        return d[48];
    endfunction

    // Configuration registers.
    logic [FREQ_W-1:0]  gps_f1_reg, gps_f2_reg, bds_f1_reg, bds_f2_reg;
    logic [LIMIT_W-1:0] mw_limit_reg, gf_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gps_f1_reg   <= GPS_F1_RST;
            gps_f2_reg   <= GPS_F2_RST;
            bds_f1_reg   <= BDS_F1_RST;
            bds_f2_reg   <= BDS_F2_RST;
            mw_limit_reg <= MW_LIMIT_RST;
            gf_limit_reg <= GF_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GPS_F1:   gps_f1_reg   <= cfg_wdata[FREQ_W-1:0];
                REG_GPS_F2:   gps_f2_reg   <= cfg_wdata[FREQ_W-1:0];
                REG_BDS_F1:   bds_f1_reg   <= cfg_wdata[FREQ_W-1:0];
                REG_BDS_F2:   bds_f2_reg   <= cfg_wdata[FREQ_W-1:0];
                REG_MW_LIMIT: mw_limit_reg <= cfg_wdata;
                REG_GF_LIMIT: gf_limit_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Input beat fields.
    logic [PRN_W-1:0]  in_prn;
    logic [DATA_W-1:0] in_ra, in_rb, in_pa, in_pb;
    logic [FREQ_W-1:0] in_fa, in_fb;

    assign in_prn = s_tdata[5:0];
    assign in_ra  = s_tdata[53:6];
    assign in_rb  = s_tdata[101:54];
    assign in_pa  = s_tdata[149:102];
    assign in_pb  = s_tdata[197:150];
    assign in_fa  = s_tuser ? bds_f1_reg : gps_f1_reg;
    assign in_fb  = s_tuser ? bds_f2_reg : gps_f2_reg;

    logic              sys_reg, eoe_reg, missing_reg;
    logic [PRN_W-1:0]  prn_reg;
    logic [DATA_W-1:0] ra_reg, rb_reg, pa_reg, pb_reg;
    logic [FREQ_W-1:0] fa_reg, fb_reg;
    logic [COEF_W-1:0] fa2_reg, fb2_reg;

    // Working registers.
    logic [ACC_W-1:0]  acc_reg, quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [COEF_W-1:0] d_reg;
    logic              den_neg_reg, num_neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_neg_reg, prod_hi_reg;
    logic [Q_W-1:0]    wl_reg, nl_reg;
    logic [DATA_W-1:0] mw_reg, gf_reg, pif_reg, prev_mw_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              valid_reg;

    // Table bookkeeping.
    logic              bank_reg;
    logic [FILL_W-1:0] fill_reg, prev_fill_reg, srch_reg;

    logic [KEY_W-1:0] key;
    assign key = {1'b1, sys_reg, prn_reg};

    // Divisor for the current combination.
    logic [25:0] den;
    logic [25:0] den_mag;
    always_comb
    begin
        case (cmd.sel)
            SEL_WL:  den = {14'd0, fa_reg} - {14'd0, fb_reg};
            SEL_NL:  den = {14'd0, fa_reg} + {14'd0, fb_reg};
            default: den = {2'd0, fa2_reg} - {2'd0, fb2_reg};
        endcase
        den_mag = den[25] ? (26'd0 - den) : den;
    end

    // Multiplier operand selection: step bit 1 picks the second term, bit 0 the upper half.
    logic [DATA_W-1:0] op_x, op_y, op, op_mag;
    logic [COEF_W-1:0] coef_x, coef_y, coef, op_half;
    logic              sub;
    always_comb
    begin
        if (cmd.sel == SEL_WL)
        begin
            op_x = pa_reg;
            op_y = pb_reg;
        end
        else
        begin
            op_x = ra_reg;
            op_y = rb_reg;
        end
        if (cmd.sel == SEL_IF)
        begin
            coef_x = fa2_reg;
            coef_y = fb2_reg;
        end
        else
        begin
            coef_x = {12'd0, fa_reg};
            coef_y = {12'd0, fb_reg};
        end
        sub     = (cmd.sel == SEL_WL) || (cmd.sel == SEL_IF);
        op      = cmd.step[1] ? op_y : op_x;
        coef    = cmd.step[1] ? coef_y : coef_x;
        op_mag  = op[DATA_W-1] ? (48'd0 - op) : op;
        op_half = cmd.step[0] ? op_mag[47:24] : op_mag[23:0];
    end

    logic [ACC_W-1:0] prod_ext;
    assign prod_ext = prod_hi_reg ? {8'd0, prod_reg, 24'd0} : {32'd0, prod_reg};

    // Divider step and rounding.
    logic [REM_W-1:0] trial;
    logic             trial_ge;
    logic             round_up;
    logic [ACC_W:0]   q_round;
    logic [60:0]      q_mag;
    logic [Q_W-1:0]   q_res;
    always_comb
    begin
        trial    = {rem_reg[REM_W-2:0], quo_reg[ACC_W-1]};
        trial_ge = trial >= {1'b0, d_reg};
        round_up = {rem_reg, 1'b0} >= {2'b0, d_reg};
        q_round  = {1'b0, quo_reg} + (ACC_W + 1)'(round_up);
        q_mag    = (q_round > Q_CLAMP) ? Q_CLAMP[60:0] : q_round[60:0];
        if (d_reg == '0)
            q_res = '0;
        else if (num_neg_reg)
            q_res = 62'd0 - {1'b0, q_mag};
        else
            q_res = {1'b0, q_mag};
    end

    // Table entry compare.
    entry_t           rd;
    logic [48:0]      dmw, dgf, dmw_abs, dgf_abs;
    logic             ok;
    logic [CNT_W-1:0] n_cnt;
    always_comb
    begin
        rd      = entry_t'(ram_rdata);
        dmw     = {mw_reg[47], mw_reg} - {rd.mw[47], rd.mw};
        dgf     = {gf_reg[47], gf_reg} - {rd.gf[47], rd.gf};
        dmw_abs = dmw[48] ? (49'd0 - dmw) : dmw;
        dgf_abs = dgf[48] ? (49'd0 - dgf) : dgf;
        ok      = (dmw_abs < {29'd0, mw_limit_reg}) && (dgf_abs < {29'd0, gf_limit_reg});
        n_cnt   = (rd.cnt == '1) ? rd.cnt : rd.cnt + CNT_W'(1);
    end

    logic [62:0] mw_diff;
    assign mw_diff = {wl_reg[61], wl_reg} - {nl_reg[61], nl_reg};

    logic full;
    assign full = (fill_reg == FULL);

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sys_reg     <= s_tuser;
            prn_reg     <= in_prn;
            eoe_reg     <= s_tlast;
            ra_reg      <= in_ra;
            rb_reg      <= in_rb;
            pa_reg      <= in_pa;
            pb_reg      <= in_pb;
            fa_reg      <= in_fa;
            fb_reg      <= in_fb;
            fa2_reg     <= in_fa * in_fa;
            fb2_reg     <= in_fb * in_fb;
            missing_reg <= (in_ra == '0) || (in_rb == '0) || (in_pa == '0) || (in_pb == '0);
        end
        if (cmd.prep)
        begin
            acc_reg     <= '0;
            d_reg       <= den_mag[COEF_W-1:0];
            den_neg_reg <= den[25];
        end
        if (cmd.mul)
        begin
            prod_reg     <= op_half * coef;
            prod_neg_reg <= op[DATA_W-1] ^ (cmd.step[1] & sub);
            prod_hi_reg  <= cmd.step[0];
        end
        if (cmd.acc)
        begin
            acc_reg <= prod_neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
        if (cmd.div_init)
        begin
            num_neg_reg <= acc_reg[ACC_W-1] ^ den_neg_reg;
            quo_reg     <= acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
            rem_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? (trial - {1'b0, d_reg}) : trial;
            quo_reg <= {quo_reg[ACC_W-2:0], trial_ge};
        end
        if (cmd.div_fin)
        begin
            case (cmd.sel)
                SEL_WL:  wl_reg  <= q_res;
                SEL_NL:  nl_reg  <= q_res;
                SEL_IF:  pif_reg <= sat48({{2{q_res[Q_W-1]}}, q_res});
                default: mw_reg  <= prev_mw_reg + q_res[DATA_W-1:0];
            endcase
        end
        if (cmd.calc)
        begin
            mw_reg    <= sat48({mw_diff[62], mw_diff});
            gf_reg    <= sat48({{15{dgf_calc_sign(pa_reg, pb_reg)}},
                                ({pa_reg[47], pa_reg} - {pb_reg[47], pb_reg})});
            cnt_reg   <= CNT_W'(1);
            valid_reg <= 1'b1;
        end
        if (cmd.srch_chk && (rd.key == key))
        begin
            if (ok)
            begin
                cnt_reg     <= n_cnt;
                d_reg       <= {8'd0, n_cnt};
                den_neg_reg <= 1'b0;
                acc_reg     <= {{31{dmw[48]}}, dmw};
                prev_mw_reg <= rd.mw;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Table control and output beat.
    logic [FILL_W-1:0] fill_next;
    assign fill_next = full ? fill_reg : fill_reg + FILL_W'(1);

    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg, out_last_reg, out_valid_reg;
    logic                  res_valid;
    logic [DATA_W-1:0]     res_mw, res_gf, res_pif;
    logic [CNT_W-1:0]      res_cnt;

    always_comb
    begin
        res_valid = !missing_reg && valid_reg && !full;
        res_mw    = missing_reg ? '0 : mw_reg;
        res_gf    = missing_reg ? '0 : gf_reg;
        res_pif   = missing_reg ? '0 : pif_reg;
        res_cnt   = missing_reg ? '0 : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            fill_reg      <= '0;
            prev_fill_reg <= '0;
            srch_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.srch_clr)
            begin
                srch_reg <= '0;
            end
            else if (cmd.srch_rd)
            begin
                srch_reg <= srch_reg + FILL_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (eoe_reg)
                begin
                    bank_reg      <= ~bank_reg;
                    prev_fill_reg <= fill_next;
                    fill_reg      <= '0;
                end
                else
                begin
                    fill_reg <= fill_next;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {1'b0, res_cnt, res_pif, res_gf, res_mw, res_valid, prn_reg};
            out_user_reg <= sys_reg;
            out_last_reg <= eoe_reg;
        end
    end

    // A missing observation takes a slot but stores an unused key.
    always_comb
    begin
        ram_we    = cmd.finish && !full;
        ram_waddr = slot_addr(bank_reg, fill_reg);
        ram_wdata = missing_reg ? ENTRY_W'(0) : {key, mw_reg, gf_reg, cnt_reg};
        ram_re    = cmd.srch_rd;
        ram_raddr = slot_addr(~bank_reg, srch_reg);
    end

    always_comb
    begin
        sts          = '0;
        sts.missing  = missing_reg;
        sts.srch_end = (srch_reg == prev_fill_reg);
        sts.hit      = (rd.key == key);
        sts.ok       = ok;
        sts.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/gnss_cycle_slip_detector.sv =====
// Top level of the dual-frequency MW / GF cycle-slip detector.
// One observation at a time; s_tready is high only while the sequencer is idle.
// Accept to result grows with k, the previous-epoch slots scanned, and with the mean update;
// missing data skips the arithmetic. s_tready returns in the cycle after the result is issued.
// Three 80-step divisions (four with the mean) and the slot scan set it; a stalled result adds.
// Asynchronous active-low reset restores register defaults and empties both table banks.
`timescale 1ns / 1ps
module gnss_cycle_slip_detector import csd_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sat_prn[5:0], range_a[53:6], range_b[101:54], phase_a[149:102], phase_b[197:150]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // sat_system
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_prn[5:0], obs_valid[6], mw_mean[54:7], gf_value[102:55],
    // iono_free_range[150:103], smooth_count[166:151]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // out_system
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [LIMIT_W-1:0]    cfg_wdata
);

    localparam int ADDR_W = $clog2(2 * TABLE_DEPTH);

    cmd_t               cmd;
    sts_t               sts;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    csd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    csd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    csd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 * TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/csd_checker.sv =====
// Port-level checks of the cycle-slip detector, bound to the top level.
`timescale 1ns / 1ps
module csd_checker import csd_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // Only one observation is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an observation is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output beat changed");

    // A usable observation always belongs to a smoothing arc.
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[6]) |-> (m_tdata[166:151] != 16'd0))
        else $error("usable beat with zero smoothing count");

    // Zero count marks missing data: all combinations are zero and the beat is unusable.
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[166:151] == 16'd0)) |->
            ((m_tdata[150:7] == 144'd0) && !m_tdata[6]))
        else $error("missing-data beat carries nonzero values");

endmodule

bind gnss_cycle_slip_detector csd_checker u_csd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/tb_gnss_cycle_slip_detector.sv =====
// Self-checking testbench for the MW / GF cycle-slip detector: streams observations, checks every result.
`timescale 1ns / 1ps
module tb_gnss_cycle_slip_detector;
    import csd_pkg::*;

    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 40000;
    localparam int POOL = 16;

    typedef struct {
        logic              sys;
        logic [5:0]        prn;
        logic signed [47:0] ra;
        logic signed [47:0] rb;
        logic signed [47:0] pa;
        logic signed [47:0] pb;
        logic              eoe;
    } obs_t;

    typedef struct {
        logic        sys;
        logic [5:0]  prn;
        logic        ok;
        logic [47:0] mw;
        logic [47:0] gf;
        logic [47:0] pif;
        logic [15:0] cnt;
        logic        eoe;
    } slip_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [LIMIT_W-1:0]    cfg_wdata;

    gnss_cycle_slip_detector #(.TABLE_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Predictor state: configuration and both table banks.
    longint    freq [4];
    longint    mw_lim;
    longint    gf_lim;
    logic [7:0] tkey [2*DEPTH];
    longint    tmw [2*DEPTH];
    longint    tgf [2*DEPTH];
    longint    tcnt [2*DEPTH];
    int        bank;
    int        fill;

    obs_t      obs_q[$];
    slip_res_t expect_q[$];
    obs_t      cur_obs;
    int        send_idle;
    int        recv_stall;
    int        hold_left;
    int        errors;
    int        quiet_cycles;

    // Traffic pool of satellites followed from epoch to epoch.
    logic       sat_sys [POOL];
    logic [5:0] sat_prn [POOL];
    longint     sat_r [POOL];
    longint     sat_off [POOL][3];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint clip48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    // round((x*cx +/- y*cy) / den), ties away from zero, magnitude clamped to 2^60.
    function automatic longint lin_div(longint x, longint cx, longint y, longint cy,
                                       bit sub, longint den);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] num;
        logic [127:0] mag;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] r;
        bit neg;
        if (den == 0) return 0;
        a = x;
        b = y;
        num = sub ? a * cx - b * cy : a * cx + b * cy;
        neg = num < 0;
        mag = neg ? -num : num;
        if (den < 0) begin
            neg = !neg;
            d = -den;
        end else begin
            d = den;
        end
        q = mag / d;
        r = mag % d;
        if (r >= d - r) q = q + 1;
        if (q > (128'd1 << 60)) q = 128'd1 << 60;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic slip_res_t predict_slip(obs_t o);
        slip_res_t r;
        longint ra, rb, pa, pb, fa, fb, wl, nl, mw, gf, pif, dmw, dgf, n;
        int cur, prv, s;
        logic [7:0] key;
        bit hit;
        ra = o.ra; rb = o.rb; pa = o.pa; pb = o.pb;
        mw = 0; gf = 0; pif = 0;
        r.cnt = 0;
        r.ok = 1'b0;
        cur = bank * DEPTH;
        prv = (bank ^ 1) * DEPTH;
        key = {1'b1, o.sys, o.prn};
        if (ra == 0 || rb == 0 || pa == 0 || pb == 0) begin
            // Missing data burns a slot that can never match.
            if (fill < DEPTH) begin
                tkey[cur + fill] = 8'd0;
                fill++;
            end
        end else begin
            fa = o.sys ? freq[REG_BDS_F1] : freq[REG_GPS_F1];
            fb = o.sys ? freq[REG_BDS_F2] : freq[REG_GPS_F2];
            wl = lin_div(pa, fa, pb, fb, 1'b1, fa - fb);
            nl = lin_div(ra, fa, rb, fb, 1'b0, fa + fb);
            mw = clip48(wl - nl);
            gf = clip48(pa - pb);
            pif = clip48(lin_div(ra, fa * fa, rb, fb * fb, 1'b1, fa * fa - fb * fb));
            r.cnt = 1;
            r.ok = 1'b1;
            hit = 1'b0;
            for (int j = 0; j < DEPTH && !hit; j++) begin
                s = prv + j;
                if (tkey[s] == key) begin
                    hit = 1'b1;
                    dmw = mw - tmw[s];
                    dgf = gf - tgf[s];
                    if (dmw < 0) dmw = -dmw;
                    if (dgf < 0) dgf = -dgf;
                    if (dmw < mw_lim && dgf < gf_lim) begin
                        n = tcnt[s] + 1;
                        if (n > 65535) n = 65535;
                        mw = tmw[s] + lin_div(mw - tmw[s], 1, 0, 0, 1'b0, n);
                        r.cnt = n[15:0];
                    end else begin
                        r.ok = 1'b0;
                    end
                end
            end
            if (fill < DEPTH) begin
                s = cur + fill;
                tkey[s] = key;
                tmw[s] = mw;
                tgf[s] = gf;
                tcnt[s] = r.cnt;
                fill++;
            end else begin
                r.ok = 1'b0;
            end
        end
        r.sys = o.sys;
        r.prn = o.prn;
        r.mw = mw[47:0];
        r.gf = gf[47:0];
        r.pif = pif[47:0];
        r.eoe = o.eoe;
        if (o.eoe) begin
            bank ^= 1;
            for (int j = 0; j < DEPTH; j++) tkey[bank * DEPTH + j] = 8'd0;
            fill = 0;
        end
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    // Sender side.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expect_q.push_back(predict_slip(cur_obs));
            if (!s_tvalid || s_tready) begin
                if (obs_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_obs = obs_q.pop_front();
                    s_tdata <= {2'b00, cur_obs.pb, cur_obs.pa, cur_obs.rb, cur_obs.ra,
                                cur_obs.prn};
                    s_tuser <= cur_obs.sys;
                    s_tlast <= cur_obs.eoe;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side and result check.
    always @(posedge clk or negedge rst_n) begin
        slip_res_t w;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expect_q.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected", $time);
                    errors++;
                end else begin
                    w = expect_q.pop_front();
                    if (m_tuser !== w.sys) report("out_system", m_tuser, w.sys);
                    if (m_tdata[5:0] !== w.prn) report("out_prn", m_tdata[5:0], w.prn);
                    if (m_tdata[6] !== w.ok) report("obs_valid", m_tdata[6], w.ok);
                    if (m_tdata[54:7] !== w.mw) report("mw_mean", m_tdata[54:7], w.mw);
                    if (m_tdata[102:55] !== w.gf) report("gf_value", m_tdata[102:55], w.gf);
                    if (m_tdata[150:103] !== w.pif)
                        report("iono_free_range", m_tdata[150:103], w.pif);
                    if (m_tdata[166:151] !== w.cnt)
                        report("smooth_count", m_tdata[166:151], w.cnt);
                    if (m_tlast !== w.eoe) report("out_epoch_end", m_tlast, w.eoe);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_obs(logic sys, logic [5:0] prn, longint ra, longint rb,
                           longint pa, longint pb, logic eoe);
        obs_t o;
        o.sys = sys; o.prn = prn;
        o.ra = ra[47:0]; o.rb = rb[47:0]; o.pa = pa[47:0]; o.pb = pb[47:0];
        o.eoe = eoe;
        obs_q.push_back(o);
    endtask

    function automatic longint rand48();
        return longint'({$urandom, $urandom}) >>> 16;
    endfunction

    task automatic add_noise(logic eoe);
        longint v [4];
        for (int k = 0; k < 4; k++) begin
            v[k] = rand48();
            if ($urandom_range(9) == 0) v[k] = 0;
        end
        add_obs($urandom, $urandom, v[0], v[1], v[2], v[3], eoe);
    endtask

    task automatic new_pool();
        for (int k = 0; k < POOL; k++) begin
            sat_sys[k] = $urandom;
            sat_prn[k] = $urandom;
            sat_r[k] = (longint'(20_000_000) + $urandom_range(5_000_000)) <<< 12;
            for (int m = 0; m < 3; m++) sat_off[k][m] = $signed($urandom_range(40000)) - 20000;
        end
    endtask

    // Ranges and phases drift together, so MW and GF hold still unless a jump is injected.
    task automatic add_epochs(int n_epochs, int n_sats, int jump_pct, int noise_pct);
        obs_t ep[$];
        longint drift, ra, rb, pa, pb;
        int any;
        for (int e = 0; e < n_epochs; e++) begin
            any = 0;
            drift = $signed($urandom_range(2_000_000)) - 1_000_000;
            for (int k = 0; k < n_sats; k++) begin
                sat_r[k] += drift;
                if ($urandom_range(99) < noise_pct) begin
                    add_noise(1'b0);
                    any++;
                end else if ($urandom_range(9) != 0) begin
                    ra = sat_r[k] + $signed($urandom_range(6)) - 3;
                    rb = ra + sat_off[k][0];
                    pa = ra + sat_off[k][1] + $signed($urandom_range(6)) - 3;
                    pb = ra + sat_off[k][2];
                    if ($urandom_range(99) < jump_pct) pa += longint'($urandom_range(1, 3)) <<< 15;
                    case ($urandom_range(40))
                        0: ra = 0;
                        1: rb = 0;
                        2: pa = 0;
                        3: pb = 0;
                        default: ;
                    endcase
                    add_obs(sat_sys[k], sat_prn[k], ra, rb, pa, pb, 1'b0);
                    any++;
                end
            end
            if (any == 0) add_noise(1'b1);
            else obs_q[obs_q.size() - 1].eoe = 1'b1;
        end
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, longint value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value[LIMIT_W-1:0];
        if (idx == REG_MW_LIMIT) mw_lim = value & 64'hF_FFFF;
        else if (idx == REG_GF_LIMIT) gf_lim = value & 64'hF_FFFF;
        else freq[idx] = value & 64'hFFF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        while (obs_q.size() > 0 || s_tvalid || expect_q.size() > 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_cfg(longint g1, longint g2, longint b1, longint b2,
                           longint mwl, longint gfl);
        cfg_write(REG_GPS_F1, g1);
        cfg_write(REG_GPS_F2, g2);
        cfg_write(REG_BDS_F1, b1);
        cfg_write(REG_BDS_F2, b2);
        cfg_write(REG_MW_LIMIT, mwl);
        cfg_write(REG_GF_LIMIT, gfl);
        @(negedge clk);
    endtask

    initial begin
        longint big, r0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        errors = 0;
        quiet_cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_left = 0;
        freq[REG_GPS_F1] = GPS_F1_RST;
        freq[REG_GPS_F2] = GPS_F2_RST;
        freq[REG_BDS_F1] = BDS_F1_RST;
        freq[REG_BDS_F2] = BDS_F2_RST;
        mw_lim = MW_LIMIT_RST;
        gf_lim = GF_LIMIT_RST;
        for (int j = 0; j < 2 * DEPTH; j++) tkey[j] = 8'd0;
        bank = 0;
        fill = 0;
        new_pool();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings.
        big = 64'sh7FFF_FFFF_FFFF;
        r0 = longint'(22_000_000) <<< 12;
        add_obs(0, 0, big, big, big, big, 0);
        add_obs(1, 63, -big - 1, -big - 1, -big - 1, -big - 1, 0);
        add_obs(0, 1, big, -big - 1, big, -big - 1, 0);
        add_obs(1, 2, -big - 1, big, -big - 1, big, 0);
        add_obs(0, 3, 0, r0, r0, r0, 0);
        add_obs(0, 4, r0, 0, r0, r0, 0);
        add_obs(0, 5, r0, r0, 0, r0, 0);
        add_obs(0, 6, r0, r0, r0, 0, 0);
        add_obs(0, 7, r0, r0 + 900, r0 + 50, r0 - 40, 0);
        add_obs(0, 7, r0 + 4096, r0 + 900, r0 + 50, r0 - 40, 0);
        add_obs(1, 7, r0, r0 + 900, r0 + 50, r0 - 40, 1);
        // Next epoch: slow drift matches, the GF jump does not, the duplicate uses its first slot.
        add_obs(0, 7, r0 + 77, r0 + 977, r0 + 127, r0 + 37, 0);
        add_obs(1, 7, r0, r0 + 900, r0 + 50 + 300, r0 - 40, 0);
        add_obs(0, 3, r0, r0, r0, r0, 1);
        add_obs(0, 7, r0 + 150, r0 + 1050, r0 + 200, r0 + 110, 1);
        add_epochs(30, 8, 5, 5);
        drain();

        // Extreme frequencies, widest limits, sender idling.
        set_cfg(4095, 1, 1, 4095, 64'hF_FFFF, 64'hF_FFFF);
        send_idle = 50;
        add_epochs(25, 10, 10, 15);
        drain();

        // Equal frequencies and tightest limits, receiver stalling with one long hold-off.
        set_cfg(1000, 1000, 1575, 1176, 0, 1);
        send_idle = 0;
        recv_stall = 50;
        hold_left = 3000;
        add_epochs(25, 10, 5, 15);
        drain();

        // Default-like settings, both sides idling, then one over-full epoch.
        set_cfg(1540, 1200, 1526, 1240, 12288, 205);
        send_idle = 16;
        recv_stall = 16;
        new_pool();
        add_epochs(12, 12, 5, 10);
        for (int k = 0; k < 70; k++)
            add_obs(sat_sys[k % POOL], sat_prn[k % POOL], sat_r[k % POOL],
                    sat_r[k % POOL] + 500, sat_r[k % POOL] + 60, sat_r[k % POOL] - 20, k == 69);
        add_epochs(4, 12, 5, 10);
        drain();

        // Random settings, no idling.
        set_cfg($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1, 4095),
                $urandom_range(1, 4095), $urandom_range(1 << 20) + 4096, $urandom_range(1 << 16));
        send_idle = 0;
        recv_stall = 0;
        add_epochs(25, 10, 10, 15);
        drain();
        repeat (50) @(negedge clk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
